@@ hdl/lpe_pkg.sv @@
package lpe_pkg;

    localparam int FIELD_W     = 16;
    localparam int DEG_W       = 6;
    localparam int WORK_BITS   = 30;
    localparam int PW          = 32;
    localparam int PROD_W      = 2 * PW;
    localparam int KMAX_W      = 7;
    localparam int NUM_W       = 40;
    localparam int A_W         = 38;
    localparam int RECIP_SHIFT = 44;
    localparam int M_W         = 44;
    localparam int M_LO_W      = 22;
    localparam int PH_W        = A_W + M_W - M_LO_W;
    localparam int PL_W        = A_W + M_LO_W;
    localparam int SUM_W       = PH_W + M_LO_W;

    typedef enum logic [2:0] {
        DP_NOP,
        DP_LOAD,
        DP_MUL,
        DP_RND,
        DP_NUM,
        DP_DIVA,
        DP_DIVB,
        DP_FIN
    } t_dp_op;

    typedef struct packed {
        t_dp_op              op;
        logic [KMAX_W-1:0]   k;
        logic                zero_deg;
    } t_dp_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_RND,
        ST_NUM,
        ST_DIVA,
        ST_DIVB,
        ST_FIN
    } t_ctrl_state;

endpackage

@@ hdl/lpe_datapath.sv @@
module lpe_datapath
    import lpe_pkg::*;
#(
    parameter int FRAC_BITS = 14
) (
    input  logic                      i_clk,
    input  t_dp_cmd                   i_cmd,
    input  logic signed [FIELD_W-1:0] i_point,
    output logic signed [FIELD_W-1:0] o_point_echo,
    output logic signed [FIELD_W-1:0] o_poly_value
);

    localparam int SH = WORK_BITS - FRAC_BITS;
    localparam logic signed [PW-1:0] ONE      = PW'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [PW-1:0] P_ONE    = PW'(64'sd1 <<< WORK_BITS);
    localparam logic signed [PW-1:0] OUT_HALF = (SH == 0) ? PW'(0) : PW'(64'sd1 <<< (SH - 1));
    localparam logic signed [PW-1:0] OUT_ADJ  = (SH == 0) ? PW'(0) : PW'(1);
    localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(64'sd1 <<< (WORK_BITS - 1));
    localparam logic signed [PROD_W-1:0] PROD_LSB  = PROD_W'(1);

    logic [M_W-1:0] recip_rom [0:2**KMAX_W-1];

    for (genvar g = 0; g < 2**KMAX_W; g++) begin : g_recip
        localparam logic [63:0] RV = (g < 2) ? 64'd0 :
            (((64'd1 << RECIP_SHIFT) + 64'(g) - 64'd1) / 64'(g));
        assign recip_rom[g] = M_W'(RV);
    end

    logic signed [FIELD_W-1:0] r_x16;
    logic signed [PW-1:0]      r_xw;
    logic signed [PW-1:0]      r_p0;
    logic signed [PW-1:0]      r_p1;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [NUM_W-1:0]   r_c0;
    logic signed [PW-1:0]      r_t;
    logic signed [NUM_W-1:0]   r_num;
    logic                      r_neg;
    logic [PH_W-1:0]           r_ph;
    logic [PL_W-1:0]           r_pl;
    logic signed [FIELD_W-1:0] r_value;

    logic signed [PW-1:0]       xs;
    logic signed [PW-1:0]       xc;
    logic signed [KMAX_W:0]     km1_s;
    logic signed [NUM_W-1:0]    c0;
    logic signed [PROD_W-1:0]   rnd_sum;
    logic [KMAX_W:0]            odd;
    logic signed [KMAX_W+1:0]   odd_s;
    logic signed [NUM_W-1:0]    num;
    logic signed [NUM_W-1:0]    mag;
    logic [A_W-1:0]             a;
    logic [M_W-1:0]             recip;
    logic [SUM_W-1:0]           sum;
    logic [PW-1:0]              q;
    logic signed [PW-1:0]       pk;
    logic signed [PW-1:0]       y;
    logic signed [PW-1:0]       ysat;

    always_comb begin
        xs = PW'(i_point);
        if (xs > ONE) begin
            xc = ONE;
        end else if (xs < -ONE) begin
            xc = -ONE;
        end else begin
            xc = xs;
        end

        km1_s = signed'({1'b0, i_cmd.k - KMAX_W'(1)});
        c0    = NUM_W'(r_p0) * NUM_W'(km1_s);

        rnd_sum = r_prod + PROD_HALF - (r_prod[PROD_W-1] ? PROD_LSB : '0);

        odd   = {i_cmd.k, 1'b0} - (KMAX_W+1)'(1);
        odd_s = signed'({1'b0, odd});
        num   = NUM_W'(r_t) * NUM_W'(odd_s) - r_c0;

        mag   = r_num[NUM_W-1] ? -r_num : r_num;
        a     = A_W'(mag) + A_W'(i_cmd.k >> 1);
        recip = recip_rom[i_cmd.k];

        sum = {r_ph, M_LO_W'(0)} + SUM_W'(r_pl);
        q   = sum[RECIP_SHIFT +: PW];
        pk  = r_neg ? -signed'(q) : signed'(q);

        y = (r_p1 + OUT_HALF - (r_p1[PW-1] ? OUT_ADJ : PW'(0))) >>> SH;
        if (y > ONE) begin
            ysat = ONE;
        end else if (y < -ONE) begin
            ysat = -ONE;
        end else begin
            ysat = y;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_LOAD: begin
                r_x16 <= xc[FIELD_W-1:0];
                r_xw  <= xc <<< SH;
                r_p0  <= P_ONE;
                r_p1  <= i_cmd.zero_deg ? P_ONE : (xc <<< SH);
            end
            DP_MUL: begin
                r_prod <= PROD_W'(r_xw) * PROD_W'(r_p1);
                r_c0   <= c0;
            end
            DP_RND: begin
                r_t <= PW'(rnd_sum >>> WORK_BITS);
            end
            DP_NUM: begin
                r_num <= num;
            end
            DP_DIVA: begin
                r_neg <= r_num[NUM_W-1];
                r_ph  <= PH_W'(a) * PH_W'(recip[M_W-1:M_LO_W]);
                r_pl  <= PL_W'(a) * PL_W'(recip[M_LO_W-1:0]);
            end
            DP_DIVB: begin
                r_p0 <= r_p1;
                r_p1 <= pk;
            end
            DP_FIN: begin
                r_value <= ysat[FIELD_W-1:0];
            end
            default: begin
            end
        endcase
    end

    assign o_point_echo = r_x16;
    assign o_poly_value = r_value;

endmodule

@@ hdl/lpe_ctrl.sv @@
module lpe_ctrl
    import lpe_pkg::*;
#(
    parameter int MAX_DEGREE = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [DEG_W-1:0] i_cfg_data,
    output t_dp_cmd          o_cmd,
    output logic             o_strobe
);

    localparam int K_W = $clog2(MAX_DEGREE + 1);

    t_ctrl_state      r_state;
    t_ctrl_state      n_state;
    logic [DEG_W-1:0] r_degree;
    logic [K_W-1:0]   r_n;
    logic [K_W-1:0]   n_n;
    logic [K_W-1:0]   r_k;
    logic [K_W-1:0]   n_k;
    logic             r_strobe;
    logic             n_strobe;
    logic [K_W-1:0]   n_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_degree <= '0;
            r_n      <= '0;
            r_k      <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_n      <= n_n;
            r_k      <= n_k;
            r_strobe <= n_strobe;
            if (i_cfg_valid && o_cfg_ready) begin
                r_degree <= i_cfg_data;
            end
        end
    end

    always_comb begin
        if (int'(r_degree) > MAX_DEGREE) begin
            n_eff = K_W'(MAX_DEGREE);
        end else begin
            n_eff = K_W'(r_degree);
        end

        n_state        = r_state;
        n_n            = r_n;
        n_k            = r_k;
        n_strobe       = 1'b0;
        o_cmd.op       = DP_NOP;
        o_cmd.k        = KMAX_W'(r_k);
        o_cmd.zero_deg = (n_eff == '0);

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.op = DP_LOAD;
                    n_n      = n_eff;
                    n_k      = K_W'(2);
                    n_state  = (n_eff < K_W'(2)) ? ST_FIN : ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.op = DP_MUL;
                n_state  = ST_RND;
            end
            ST_RND: begin
                o_cmd.op = DP_RND;
                n_state  = ST_NUM;
            end
            ST_NUM: begin
                o_cmd.op = DP_NUM;
                n_state  = ST_DIVA;
            end
            ST_DIVA: begin
                o_cmd.op = DP_DIVA;
                n_state  = ST_DIVB;
            end
            ST_DIVB: begin
                o_cmd.op = DP_DIVB;
                if (r_k == r_n) begin
                    n_state = ST_FIN;
                end else begin
                    n_k     = r_k + K_W'(1);
                    n_state = ST_MUL;
                end
            end
            ST_FIN: begin
                o_cmd.op = DP_FIN;
                n_strobe = 1'b1;
                n_state  = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_strobe    = r_strobe;

endmodule

@@ hdl/legendre_polynomial_eval.sv @@
// legendre polynomial evaluator, P_n(x) by the three-term recurrence
//
// request channel: drive i_point and raise start; the request is taken at
// a rising edge with start high and busy low. busy stays high until the
// result cycle, in which the next request may already be taken.
// result channel: o_point_echo (clamped x) and o_poly_value (P_n(x),
// signed Q1.FRAC_BITS, rounded and saturated) are valid for exactly one
// cycle while o_strobe is high. the receiver cannot stall this channel.
// configuration: i_cfg_data is the degree n, written when i_cfg_valid is
// high (o_cfg_ready is always high); write only while the block is idle.
// each recurrence step, for k from 2 to n, runs the states MUL, RND, NUM,
// DIVA and DIVB: one 32x32 multiply with the (k-1) coefficient product,
// rounding, the (2k-1) coefficient product and a two-part reciprocal
// multiply for the rounded division by k. n of 0 or 1 goes straight to FIN.
// reset: synchronous, active low; clears the degree to 0 and the sequencer
// to idle, with no result pending.
module legendre_polynomial_eval
    import lpe_pkg::*;
#(
    parameter int MAX_DEGREE = 32,
    parameter int FRAC_BITS  = 14
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [FIELD_W-1:0] i_point,
    output logic                      o_strobe,
    output logic signed [FIELD_W-1:0] o_point_echo,
    output logic signed [FIELD_W-1:0] o_poly_value,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [DEG_W-1:0]          i_cfg_data
);

    t_dp_cmd cmd;

    lpe_ctrl #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_cmd       (cmd),
        .o_strobe    (o_strobe)
    );

    lpe_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_cmd        (cmd),
        .i_point      (i_point),
        .o_point_echo (o_point_echo),
        .o_poly_value (o_poly_value)
    );

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but block not busy");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held longer than one cycle");

    a_strobe_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobe without preceding work");

endmodule
